[rtl/rpfs_pkg.sv]
// Shared types, constants and palette tables for the RGB palette fade sequencer.
package rpfs_pkg;

  // Field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned SlotW   = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DurW    = 16;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned NumW    = LevelW + DurW;
  localparam int unsigned StepW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegStandby = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSearch  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSuccess = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFail    = 2'd3;

  // Reset values of the fade durations
  localparam logic [DurW-1:0] StandbyFadeRst = 16'd3000;
  localparam logic [DurW-1:0] SearchFadeRst  = 16'd2500;
  localparam logic [DurW-1:0] SuccessFadeRst = 16'd2500;
  localparam logic [DurW-1:0] FailFadeRst    = 16'd1500;

  // Item kinds carried in tuser
  localparam logic CmdTick = 1'b0;
  localparam logic CmdMode = 1'b1;

  // Modes
  localparam logic [ModeW-1:0] ModeStandby = 2'd0;
  localparam logic [ModeW-1:0] ModeSearch  = 2'd1;
  localparam logic [ModeW-1:0] ModeSuccess = 2'd2;
  localparam logic [ModeW-1:0] ModeFail    = 2'd3;

  // One colour: index 0 red, 1 green, 2 blue
  typedef logic [NumChan-1:0][LevelW-1:0] color_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic apply_direct;
    logic start_div;
    logic mul;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic ch_last;
    logic out_free;
  } dp_stat_t;

  // Build a colour from its three levels.
  function automatic color_t mk_color(input logic [LevelW-1:0] r,
                                      input logic [LevelW-1:0] g,
                                      input logic [LevelW-1:0] b);
    color_t c;
    c[0] = r;
    c[1] = g;
    c[2] = b;
    return c;
  endfunction

  // Palette entry for a mode; the slot is masked to the palette size.
  function automatic color_t pal_color(input logic [ModeW-1:0] mode,
                                       input logic [SlotW-1:0] slot);
    color_t c;
    c = mk_color(8'd0, 8'd0, 8'd0);
    unique case (mode)
      ModeStandby: begin
        unique case (slot)
          2'd0: c = mk_color(8'd200, 8'd200, 8'd200);
          2'd1: c = mk_color(8'd50, 8'd50, 8'd100);
          2'd2: c = mk_color(8'd20, 8'd80, 8'd40);
          default: c = mk_color(8'd100, 8'd100, 8'd100);
        endcase
      end
      ModeSearch: begin
        c = slot[0] ? mk_color(8'd200, 8'd50, 8'd0) : mk_color(8'd220, 8'd150, 8'd0);
      end
      ModeSuccess: begin
        c = slot[0] ? mk_color(8'd0, 8'd100, 8'd255) : mk_color(8'd0, 8'd255, 8'd100);
      end
      default: begin
        c = slot[0] ? mk_color(8'd255, 8'd60, 8'd0) : mk_color(8'd255, 8'd0, 8'd0);
      end
    endcase
    return c;
  endfunction

  // Slot that follows the given one within the mode's palette.
  function automatic logic [SlotW-1:0] next_slot(input logic [ModeW-1:0] mode,
                                                 input logic [SlotW-1:0] slot);
    logic [SlotW-1:0] n;
    n = slot + 2'd1;
    if (mode != ModeStandby) begin
      n = {1'b0, n[0]};
    end
    return n;
  endfunction

endpackage

[rtl/rpfs_ctrl.sv]
// Controller state machine of the RGB palette fade sequencer.
module rpfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  rpfs_pkg::dp_stat_t stat_i,
  output rpfs_pkg::dp_cmd_t  cmd_o
);
  import rpfs_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.need_div) begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_MUL;
        end else begin
          cmd_o.apply_direct = 1'b1;
          state_d            = ST_OUT;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = stat_i.ch_last ? ST_OUT : ST_MUL;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/rpfs_datapath.sv]
// Datapath of the RGB palette fade sequencer: fade state, interpolation and divider.
module rpfs_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [rpfs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rpfs_pkg::DurW-1:0]          cfg_data_i,
  input  logic [rpfs_pkg::InDataW-1:0]       s_axis_tdata,
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rpfs_pkg::OutDataW-1:0]      m_axis_tdata,
  input  rpfs_pkg::dp_cmd_t                  cmd_i,
  output rpfs_pkg::dp_stat_t                 stat_o
);
  import rpfs_pkg::*;

  // Configuration and fade state
  logic [3:0][DurW-1:0] fade_q;
  logic [ModeW-1:0]     mode_q;
  logic [SlotW-1:0]     slot_q;
  logic [TimeW-1:0]     fst_q;
  color_t               start_q, target_q, cur_q;

  // Captured request
  logic                 icmd_q;
  logic [ModeW-1:0]     ireq_q;
  logic [TimeW-1:0]     itime_q;

  // Interpolation and divider registers
  logic [DurW-1:0]      d_q, e_q;
  logic [DurW-1:0]      rem_q;
  logic [LevelW-1:0]    shf_q;
  logic [StepW-1:0]     cnt_q;
  logic [ChanW-1:0]     ch_q;

  // Output register
  logic                 out_valid_q;
  color_t               out_q;

  // Evaluation of the captured request
  logic [TimeW-1:0]     elapsed;
  logic [DurW-1:0]      dsel;
  logic                 mode_keep;

  assign elapsed   = itime_q - fst_q;
  assign dsel      = fade_q[mode_q];
  assign mode_keep = (ireq_q == mode_q) && (ireq_q != ModeStandby);

  // Products of one channel: start * (d - e) + target * e, at most 255 * d
  logic [DurW-1:0]   dme;
  logic [NumW-1:0]   prod_s, prod_t;
  logic [NumW-1:0]   num;

  assign dme     = d_q - e_q;
  assign prod_s  = {{DurW{1'b0}}, start_q[ch_q]} * {{LevelW{1'b0}}, dme};
  assign prod_t  = {{DurW{1'b0}}, target_q[ch_q]} * {{LevelW{1'b0}}, e_q};
  assign num     = prod_s + prod_t;

  // One restoring division step; the remainder always stays below d
  logic [DurW:0]   trial;
  logic [DurW-1:0] diff;
  logic            qbit;

  assign trial = {rem_q, shf_q[LevelW-1]};
  assign diff  = trial[DurW-1:0] - d_q;
  assign qbit  = (trial >= {1'b0, d_q});

  // Status to the controller
  always_comb begin
    stat_o.need_div = (icmd_q == CmdTick) && (elapsed < {{(TimeW-DurW){1'b0}}, dsel});
    stat_o.div_last = (cnt_q == {StepW{1'b1}});
    stat_o.ch_last  = (ch_q == ChanW'(NumChan - 1));
    stat_o.out_free = !out_valid_q || m_axis_tready;
  end

  // Duration registers, written from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q[RegStandby] <= StandbyFadeRst;
      fade_q[RegSearch]  <= SearchFadeRst;
      fade_q[RegSuccess] <= SuccessFadeRst;
      fade_q[RegFail]    <= FailFadeRst;
    end else if (cfg_valid_i) begin
      fade_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Captured request; payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      icmd_q  <= s_axis_tuser;
      ireq_q  <= s_axis_tdata[ModeW-1:0];
      itime_q <= s_axis_tdata[ModeW +: TimeW];
    end
  end

  // Fade state: mode changes, snaps and interpolated channels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeStandby;
      slot_q   <= 2'd1;
      fst_q    <= '0;
      start_q  <= '0;
      target_q <= pal_color(ModeStandby, 2'd0);
      cur_q    <= '0;
    end else if (cmd_i.apply_direct) begin
      if (icmd_q == CmdMode) begin
        if (!mode_keep) begin
          mode_q   <= ireq_q;
          start_q  <= cur_q;
          fst_q    <= itime_q;
          target_q <= pal_color(ireq_q, 2'd0);
          slot_q   <= 2'd1;
        end
      end else begin
        cur_q    <= target_q;
        start_q  <= target_q;
        fst_q    <= itime_q;
        target_q <= pal_color(mode_q, slot_q);
        slot_q   <= next_slot(mode_q, slot_q);
      end
    end else if (cmd_i.div_step && stat_o.div_last) begin
      cur_q[ch_q] <= {shf_q[LevelW-2:0], qbit};
    end
  end

  // Divider and channel sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ch_q  <= '0;
    end else if (cmd_i.start_div) begin
      ch_q <= '0;
    end else if (cmd_i.mul) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + StepW'(1);
      if (stat_o.div_last) begin
        ch_q <= ch_q + ChanW'(1);
      end
    end
  end

  // Divider operands and working registers; payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      d_q <= dsel;
      e_q <= elapsed[DurW-1:0];
    end
    if (cmd_i.mul) begin
      rem_q <= num[NumW-1:LevelW];
      shf_q <= num[LevelW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? diff : trial[DurW-1:0];
      shf_q <= {shf_q[LevelW-2:0], qbit};
    end
  end

  // Output register, freeing the input side while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= cur_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

[rtl/rgb_palette_fade_sequencer_top.sv]
// Top level of the RGB palette fade sequencer: controller and datapath.
//
//  Channel  Direction  Handshake                      Payload
//  s_axis   in         s_axis_tvalid / s_axis_tready  tdata: new_mode, time_ms; tuser: cmd
//  m_axis   out        m_axis_tvalid / m_axis_tready  tdata: red, green, blue level
//  cfg      in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i (duration, ms)
//
// A mode request or a tick that ends a fade goes through the evaluate and output states.
// A tick inside a fade goes through the multiply and divide states: each of the three
// channels has its products formed, then eight steps of the shared restoring divider.
// One request is processed at a time; the next is accepted once the result has moved
// into the output register, which holds it while m_axis_tready is low.
// Reset is asynchronous and active low; no clearing pass is needed after it.
module rgb_palette_fade_sequencer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Requests: [1:0] new_mode, [33:2] time_ms, zero padded to 40 bits
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rpfs_pkg::InDataW-1:0]        s_axis_tdata,
  // Kind: [0] cmd
  input  logic                                s_axis_tuser,
  // Results: [7:0] red_level, [15:8] green_level, [23:16] blue_level
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rpfs_pkg::OutDataW-1:0]       m_axis_tdata,
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rpfs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [rpfs_pkg::DurW-1:0]           cfg_data_i
);
  import rpfs_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  rpfs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (dp_stat),
    .cmd_o         (dp_cmd)
  );

  rpfs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat)
  );

endmodule
